[rtl/core/zhp_pkg.sv]
// Package for the Z_n squared harmonic power statistic.
// Holds the payload and internal types, fixed widths and the quarter-wave sine table.
// No dependencies.
`default_nettype none
package zhp_pkg;

  localparam int PHASE_W = 16;
  localparam int WEIGHT_W = 16;
  localparam int HARM_N = 8;
  localparam int HARM_W = 3;
  localparam int NH_W = 4;
  localparam int COUNT_W = 21;
  localparam logic [COUNT_W-1:0] MAX_EVENTS = COUNT_W'(1 << 20);
  localparam int ACC_W = 52;
  localparam int TRIG_W = 16;
  localparam int PROD_W = 33;
  localparam int NUM_W = 108;
  localparam int DEN_W = 34;
  localparam int QUOT_W = 64;
  localparam int DEN_SHIFT = 13;
  localparam int TAB_N = 257;
  localparam int TAB_IDX_W = 9;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic REG_NUM_HARMONICS = 1'b0;
  localparam logic REG_WEIGHTED_MODE = 1'b1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Rounded-up reciprocals of the Taylor series denominators (n - 1) * n.
  localparam int RECIP_SHIFT = 48;
  localparam longint unsigned RECIP_6 = ((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6;
  localparam longint unsigned RECIP_20 = ((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20;
  localparam longint unsigned RECIP_42 = ((64'd1 << RECIP_SHIFT) + 64'd41) / 64'd42;
  localparam longint unsigned RECIP_72 = ((64'd1 << RECIP_SHIFT) + 64'd71) / 64'd72;
  localparam longint unsigned RECIP_110 = ((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110;
  localparam longint unsigned RECIP_156 = ((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156;
  localparam longint unsigned RECIP_210 = ((64'd1 << RECIP_SHIFT) + 64'd209) / 64'd210;

  typedef struct packed {
    logic [PHASE_W-1:0] event_phase;
    logic [WEIGHT_W-1:0] event_weight;
    logic last_event;
  } event_t;

  typedef struct packed {
    logic [63:0] zn2_value;
    logic saturated;
    logic [COUNT_W-1:0] events_counted;
  } result_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] cos_sum;
    logic signed [ACC_W-1:0] sin_sum;
  } acc_pair_t;

  typedef struct packed {
    logic en;
    logic [HARM_W-1:0] addr;
    acc_pair_t data;
  } acc_wr_t;

  typedef struct packed {
    logic done;
    logic ovf;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

  typedef logic [TRIG_W-1:0] sin_tab_t [TAB_N];

  // Sine over one quadrant in Q15, from a truncated odd Taylor series in Q30.
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned recip;
    logic [127:0] wide;
    longint sum;
    longint q;
    bit neg;
    int j;
    int n;
    for (j = 0; j < TAB_N; j++) begin
      r = longint'(j) << 22;
      x = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      neg = 1'b1;
      for (n = 3; n <= 15; n += 2) begin
        unique case (n)
          3: recip = RECIP_6;
          5: recip = RECIP_20;
          7: recip = RECIP_42;
          9: recip = RECIP_72;
          11: recip = RECIP_110;
          13: recip = RECIP_156;
          default: recip = RECIP_210;
        endcase
        wide = 128'((term * x2) >> 30) * 128'(recip);
        term = 64'(wide >> RECIP_SHIFT);
        sum = neg ? sum - longint'(term) : sum + longint'(term);
        neg = !neg;
      end
      if (sum < 0) sum = 0;
      q = (sum + 16384) >>> 15;
      if (q > 32767) q = 32767;
      t[j] = q[TRIG_W-1:0];
    end
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage
`default_nettype wire

[rtl/core/zhp_trig.sv]
// Sine and cosine lookup of a harmonic phase in Q15.
// Uses the quarter-wave table and types from zhp_pkg.
`default_nettype none
module zhp_trig (
  input  wire logic [zhp_pkg::PHASE_W-1:0] phase,
  output logic signed [zhp_pkg::TRIG_W-1:0] sin_q15,
  output logic signed [zhp_pkg::TRIG_W-1:0] cos_q15
);
  import zhp_pkg::*;

  logic [1:0] quad;
  logic [7:0] frac;
  logic signed [TRIG_W-1:0] sa;
  logic signed [TRIG_W-1:0] sb;

  assign quad = phase[15:14];
  assign frac = phase[13:6];
  assign sa = SIN_TAB[{1'b0, frac}];
  assign sb = SIN_TAB[TAB_IDX_W'(9'd256 - {1'b0, frac})];

  always_comb begin
    unique case (quad)
      2'd0: begin
        sin_q15 = sa;
        cos_q15 = sb;
      end
      2'd1: begin
        sin_q15 = sb;
        cos_q15 = -sa;
      end
      2'd2: begin
        sin_q15 = -sa;
        cos_q15 = -sb;
      end
      default: begin
        sin_q15 = -sb;
        cos_q15 = sa;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/zhp_acc_mem.sv]
// Harmonic accumulator memory: one cosine and sine sum pair per harmonic.
// Synchronous read, with the data registered in the cycle after rd_en; valid bits make unwritten entries read zero.
`default_nettype none
module zhp_acc_mem (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic clear,
  input  wire logic rd_en,
  input  wire logic [zhp_pkg::HARM_W-1:0] rd_addr,
  output zhp_pkg::acc_pair_t rd_data,
  input  wire zhp_pkg::acc_wr_t wr
);
  import zhp_pkg::*;

  acc_pair_t mem [HARM_N];
  acc_pair_t rd_q;
  logic rd_valid;
  logic [HARM_N-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (clear) begin
        valid <= '0;
      end else if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule
`default_nettype wire

[rtl/core/zhp_div.sv]
// Restoring divider, one quotient bit per cycle, with quotient overflow detection.
// Uses widths and the result type from zhp_pkg.
`default_nettype none
module zhp_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [zhp_pkg::NUM_W-1:0] num,
  input  wire logic [zhp_pkg::DEN_W-1:0] den,
  output zhp_pkg::div_res_t res
);
  import zhp_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] rem;
  logic [QUOT_W-1:0] quot;
  logic ovf;
  logic done;
  logic [DEN_W:0] rem_x;
  logic ge;

  assign rem_x = {rem, num_sh[NUM_W-1]};
  assign ge = rem_x >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(NUM_W - 1);
        num_sh <= num;
        rem <= '0;
        quot <= '0;
        ovf <= 1'b0;
      end else if (busy) begin
        rem <= ge ? DEN_W'(rem_x - {1'b0, den}) : rem_x[DEN_W-1:0];
        quot <= {quot[QUOT_W-2:0], ge};
        ovf <= ovf | quot[QUOT_W-1];
        num_sh <= {num_sh[NUM_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.ovf = ovf;
  assign res.quot = quot;

endmodule
`default_nettype wire

[rtl/core/zn2_harmonic_power_statistic.sv]
// Top level of the Z_n squared harmonic power statistic.
// Depends on zhp_pkg, zhp_trig, zhp_acc_mem and zhp_div.
//
//   Channel  Signals                          Direction  Payload
//   event    event_valid/event_stall          in         event_data (event_t)
//   result   result_valid/result_stall        out        result_data (result_t)
//   config   cfg_we/cfg_index/cfg_data        in         4-bit register value
//
// An event passes through the accepting cycle, eight read-modify-write passes
// through the accumulator memory, one harmonic per cycle, and a pipeline drain
// and handoff. A last event adds squaring of the nh harmonic sums on one 26x26
// multiplier, the bit-serial divider and the loading of the result. Reset clears
// control state and the accumulators at once. A stalled result waits in the
// output register while events flow.
`default_nettype none
module zn2_harmonic_power_statistic (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic event_valid,
  output logic event_stall,
  input  wire zhp_pkg::event_t event_data,
  output logic result_valid,
  input  wire logic result_stall,
  output zhp_pkg::result_t result_data,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [3:0] cfg_data
);
  import zhp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACC, ST_SUM_RD, ST_SUM_LAT, ST_SUM_MUL, ST_SUM_FIN, ST_DIV, ST_LOAD
  } state_t;

  localparam logic [1:0] SQ_LOW = 2'd0;
  localparam logic [1:0] SQ_CROSS = 2'd1;
  localparam logic [1:0] SQ_HIGH = 2'd2;

  state_t state;
  logic [NH_W-1:0] num_harmonics;
  logic weighted_mode;
  logic [COUNT_W-1:0] event_count;
  logic overflow_seen;
  logic [PHASE_W-1:0] ev_phase;
  logic [WEIGHT_W-1:0] ev_weight;
  logic ev_last;
  logic [PHASE_W-1:0] harm_phase;
  logic [HARM_W:0] iss;
  logic s1_v;
  logic [HARM_W-1:0] s1_addr;
  logic signed [TRIG_W-1:0] s1_sin;
  logic signed [TRIG_W-1:0] s1_cos;
  logic s2_v;
  logic [HARM_W-1:0] s2_addr;
  logic signed [PROD_W-1:0] s2_prod_c;
  logic signed [PROD_W-1:0] s2_prod_s;
  acc_pair_t s2_acc;
  logic [HARM_W-1:0] harm;
  logic [ACC_W-1:0] abs_c;
  logic [ACC_W-1:0] abs_s;
  logic sq_sel;
  logic [1:0] sq_part;
  logic prod_v;
  logic [1:0] prod_part;
  logic [ACC_W-1:0] prod;
  logic [NUM_W-1:0] sum_acc;
  logic div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;

  logic accept;
  logic out_free;
  logic issue;
  logic rd_en;
  logic [HARM_W-1:0] rd_addr;
  acc_pair_t rd_data;
  acc_wr_t wr;
  logic mem_clear;
  logic signed [TRIG_W-1:0] trig_sin;
  logic signed [TRIG_W-1:0] trig_cos;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [PROD_W-1:0] prod_s;
  logic signed [ACC_W:0] new_c;
  logic signed [ACC_W:0] new_s;
  logic sat_c;
  logic sat_s;
  logic [HARM_W-1:0] nh_last;
  logic [ACC_W-1:0] sq_op;
  logic [25:0] mul_x;
  logic [25:0] mul_y;
  logic [NUM_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] cur_c;
  logic signed [ACC_W-1:0] cur_s;
  div_res_t div_res;

  assign event_stall = (state != ST_IDLE);
  assign accept = event_valid && !event_stall;
  assign out_free = !result_valid || !result_stall;
  assign issue = (state == ST_ACC) && (iss < HARM_N);
  assign rd_en = issue || (state == ST_SUM_RD);
  assign rd_addr = issue ? iss[HARM_W-1:0] : harm;
  assign mem_clear = (state == ST_LOAD) && out_free;

  zhp_trig u_trig (
    .phase(harm_phase),
    .sin_q15(trig_sin),
    .cos_q15(trig_cos)
  );

  zhp_acc_mem u_mem (
    .clk(clk),
    .rst(rst),
    .clear(mem_clear),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr(wr)
  );

  zhp_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num(div_num),
    .den(div_den),
    .res(div_res)
  );

  assign prod_c = s1_cos * $signed({1'b0, ev_weight});
  assign prod_s = s1_sin * $signed({1'b0, ev_weight});

  always_comb begin
    new_c = {s2_acc.cos_sum[ACC_W-1], s2_acc.cos_sum} + (ACC_W+1)'(s2_prod_c);
    new_s = {s2_acc.sin_sum[ACC_W-1], s2_acc.sin_sum} + (ACC_W+1)'(s2_prod_s);
    sat_c = new_c[ACC_W] != new_c[ACC_W-1];
    sat_s = new_s[ACC_W] != new_s[ACC_W-1];
    wr.en = s2_v;
    wr.addr = s2_addr;
    wr.data.cos_sum = sat_c ? (new_c[ACC_W] ? ACC_MIN : ACC_MAX) : new_c[ACC_W-1:0];
    wr.data.sin_sum = sat_s ? (new_s[ACC_W] ? ACC_MIN : ACC_MAX) : new_s[ACC_W-1:0];
  end

  always_comb begin
    if (num_harmonics == '0) begin
      nh_last = '0;
    end else if (num_harmonics > NH_W'(HARM_N)) begin
      nh_last = HARM_W'(HARM_N - 1);
    end else begin
      nh_last = HARM_W'(num_harmonics - 1'b1);
    end
  end

  assign cur_c = rd_data.cos_sum;
  assign cur_s = rd_data.sin_sum;
  assign sq_op = sq_sel ? abs_s : abs_c;
  assign mul_x = (sq_part == SQ_HIGH) ? sq_op[51:26] : sq_op[25:0];
  assign mul_y = (sq_part == SQ_LOW) ? sq_op[25:0] : sq_op[51:26];

  always_comb begin
    unique case (prod_part)
      SQ_LOW: prod_ext = NUM_W'(prod);
      SQ_CROSS: prod_ext = NUM_W'(prod) << 26;
      default: prod_ext = NUM_W'(prod) << 52;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      num_harmonics <= NH_W'(2);
      weighted_mode <= 1'b0;
      event_count <= '0;
      overflow_seen <= 1'b0;
      iss <= '0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      prod_v <= 1'b0;
      div_start <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NUM_HARMONICS: num_harmonics <= cfg_data;
          REG_WEIGHTED_MODE: weighted_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      s1_v <= issue;
      if (issue) begin
        s1_addr <= iss[HARM_W-1:0];
        s1_sin <= trig_sin;
        s1_cos <= trig_cos;
        harm_phase <= harm_phase + ev_phase;
        iss <= iss + 1'b1;
      end
      s2_v <= s1_v;
      if (s1_v) begin
        s2_addr <= s1_addr;
        s2_prod_c <= prod_c;
        s2_prod_s <= prod_s;
        s2_acc <= rd_data;
      end
      if (s2_v && (sat_c || sat_s)) begin
        overflow_seen <= 1'b1;
      end

      prod_v <= (state == ST_SUM_MUL);
      if (state == ST_SUM_MUL) begin
        prod <= ACC_W'(mul_x * mul_y);
        prod_part <= sq_part;
      end
      if (prod_v) begin
        sum_acc <= sum_acc + (prod_part == SQ_CROSS ? prod_ext << 1 : prod_ext);
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            ev_phase <= event_data.event_phase;
            ev_weight <= weighted_mode ? event_data.event_weight : WEIGHT_W'(1);
            ev_last <= event_data.last_event;
            harm_phase <= event_data.event_phase;
            iss <= '0;
            if (event_count == MAX_EVENTS) begin
              overflow_seen <= 1'b1;
              if (event_data.last_event) begin
                harm <= '0;
                sum_acc <= '0;
                state <= ST_SUM_RD;
              end
            end else begin
              event_count <= event_count + 1'b1;
              state <= ST_ACC;
            end
          end
        end
        ST_ACC: begin
          if ((iss == HARM_N) && !s1_v && !s2_v) begin
            if (ev_last) begin
              harm <= '0;
              sum_acc <= '0;
              state <= ST_SUM_RD;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_SUM_RD: begin
          state <= ST_SUM_LAT;
        end
        ST_SUM_LAT: begin
          abs_c <= cur_c[ACC_W-1] ? ACC_W'(-cur_c) : ACC_W'(cur_c);
          abs_s <= cur_s[ACC_W-1] ? ACC_W'(-cur_s) : ACC_W'(cur_s);
          sq_sel <= 1'b0;
          sq_part <= SQ_LOW;
          state <= ST_SUM_MUL;
        end
        ST_SUM_MUL: begin
          if (sq_part == SQ_HIGH) begin
            sq_part <= SQ_LOW;
            sq_sel <= 1'b1;
            if (sq_sel) begin
              if (harm == nh_last) begin
                state <= ST_SUM_FIN;
              end else begin
                harm <= harm + 1'b1;
                state <= ST_SUM_RD;
              end
            end
          end else begin
            sq_part <= sq_part + 1'b1;
          end
        end
        ST_SUM_FIN: begin
          if (!prod_v) begin
            div_num <= sum_acc + NUM_W'({event_count, {(DEN_SHIFT-1){1'b0}}});
            div_den <= (event_count == '0) ? DEN_W'(1 << DEN_SHIFT)
                                           : {event_count, {DEN_SHIFT{1'b0}}};
            div_start <= 1'b1;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (out_free) begin
            result_valid <= 1'b1;
            result_data.zn2_value <= div_res.ovf ? '1 : div_res.quot;
            result_data.saturated <= overflow_seen || div_res.ovf;
            result_data.events_counted <= event_count;
            event_count <= '0;
            overflow_seen <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
